/* rtl/buzzer_cadence_generator_assert.svh */
`ifndef BUZZER_CADENCE_GENERATOR_ASSERT_SVH
`define BUZZER_CADENCE_GENERATOR_ASSERT_SVH

// checked on every clock edge outside reset
`define BCG_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication checked in the cycle after the antecedent, outside reset
`define BCG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bcg_pkg.sv */
package bcg_pkg;

    localparam int TICK_W  = 8;
    localparam int PAT_W   = 3;
    localparam int CMD_W   = 2;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int REG_IDX_W = 3;

    localparam int DOORBELL_REPEAT_DEF = 3;

    localparam logic [TICK_W-1:0] CFG_RESET_TICKS = 8'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } cmd_t;

    localparam logic [PAT_W-1:0] PAT_OFF       = 3'd0;
    localparam logic [PAT_W-1:0] PAT_DOORBELL  = 3'd1;
    localparam logic [PAT_W-1:0] PAT_INTRUSION = 3'd2;
    localparam logic [PAT_W-1:0] PAT_GAS       = 3'd3;
    localparam logic [PAT_W-1:0] PAT_LOCKOUT   = 3'd4;

    localparam logic [REG_IDX_W-1:0] REG_DOORBELL_ON   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DOORBELL_OFF  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INTRUSION_ON  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INTRUSION_OFF = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GAS_ON        = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GAS_OFF       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_LOCKOUT_ON    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_LOCKOUT_OFF   = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [PAT_W-1:0] pattern_sel;
    } req_t;

    typedef struct packed {
        logic             buzzer_on;
        logic [PAT_W-1:0] current_pattern;
    } rsp_t;

    typedef struct packed {
        logic [TICK_W-1:0] doorbell_on_ticks;
        logic [TICK_W-1:0] doorbell_off_ticks;
        logic [TICK_W-1:0] intrusion_on_ticks;
        logic [TICK_W-1:0] intrusion_off_ticks;
        logic [TICK_W-1:0] gas_on_ticks;
        logic [TICK_W-1:0] gas_off_ticks;
        logic [TICK_W-1:0] lockout_on_ticks;
        logic [TICK_W-1:0] lockout_off_ticks;
    } cfg_t;

    typedef struct packed {
        logic [PAT_W-1:0]  pattern;
        logic              sound_phase;
        logic [TICK_W-1:0] tick_count;
        logic [TICK_W-1:0] repeats_left;
    } bcg_state_t;

endpackage

/* rtl/bcg_step.sv */
module bcg_step
    import bcg_pkg::*;
#(
    parameter int DOORBELL_REPEAT = DOORBELL_REPEAT_DEF
)
(
    input  bcg_state_t state,
    input  cfg_t       cfg,
    input  req_t       req,
    output bcg_state_t state_next
);

    localparam logic [TICK_W-1:0] REPEAT_INIT = TICK_W'(DOORBELL_REPEAT);

    logic [TICK_W-1:0] limit;
    logic [TICK_W-1:0] count_inc;
    logic              pattern_ok;

    // phase length for the running pattern and phase
    always_comb
    begin
        case (state.pattern)
            PAT_DOORBELL:
                limit = state.sound_phase ? cfg.doorbell_on_ticks : cfg.doorbell_off_ticks;
            PAT_INTRUSION:
                limit = state.sound_phase ? cfg.intrusion_on_ticks : cfg.intrusion_off_ticks;
            PAT_GAS:
                limit = state.sound_phase ? cfg.gas_on_ticks : cfg.gas_off_ticks;
            PAT_LOCKOUT:
                limit = state.sound_phase ? cfg.lockout_on_ticks : cfg.lockout_off_ticks;
            default:
                limit = '0;
        endcase
    end

    assign count_inc  = state.tick_count + TICK_W'(1);
    assign pattern_ok = (state.pattern != PAT_OFF) && (state.pattern <= PAT_LOCKOUT);

    always_comb
    begin
        state_next = state;
        case (cmd_t'(req.cmd))
            CMD_TICK:
            begin
                if (pattern_ok)
                begin
                    if (count_inc >= limit)
                    begin
                        state_next.tick_count  = '0;
                        state_next.sound_phase = !state.sound_phase;
                        // doorbell counts its sounding phases down to a self stop
                        if (state.sound_phase && (state.pattern == PAT_DOORBELL)
                            && (state.repeats_left != '0))
                        begin
                            state_next.repeats_left = state.repeats_left - TICK_W'(1);
                            if (state.repeats_left == TICK_W'(1))
                            begin
                                state_next = '0;
                            end
                        end
                    end
                    else
                    begin
                        state_next.tick_count = count_inc;
                    end
                end
            end
            CMD_START:
            begin
                if (req.pattern_sel == PAT_OFF)
                begin
                    state_next = '0;
                end
                else if ((req.pattern_sel <= PAT_LOCKOUT) && (req.pattern_sel != state.pattern))
                begin
                    state_next.pattern      = req.pattern_sel;
                    state_next.sound_phase  = 1'b1;
                    state_next.tick_count   = '0;
                    state_next.repeats_left = (req.pattern_sel == PAT_DOORBELL) ? REPEAT_INIT : '0;
                end
            end
            CMD_STOP:
            begin
                state_next = '0;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

/* rtl/buzzer_cadence_generator.sv */
// channel   | handshake            | payload
// ----------+----------------------+--------------------------------------
// req       | req_valid/req_ready  | req.cmd, req.pattern_sel
// rsp       | rsp_valid/rsp_ready  | rsp.buzzer_on, rsp.current_pattern
// apb       | psel/penable/pready  | paddr, pwdata, prdata (8 tick lengths)
//
// one request per cycle while req_ready is high; its response is registered in the result register
// the cadence state updates at the edge that takes the request
// a stalled response only holds off new requests while the result register is full
// reset clears the cadence state and loads every tick length with 10
`include "buzzer_cadence_generator_assert.svh"

module buzzer_cadence_generator
    import bcg_pkg::*;
#(
    parameter int DOORBELL_REPEAT = DOORBELL_REPEAT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,

    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    bcg_state_t state_reg, state_next, state_calc;
    cfg_t       cfg_reg, cfg_next;
    logic       rsp_valid_reg, rsp_valid_next;
    rsp_t       rsp_reg, rsp_next;

    logic                 req_accept;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [TICK_W-1:0]    read_ticks;

    assign req_ready  = !rsp_valid_reg || rsp_ready;
    assign req_accept = req_valid && req_ready;
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign reg_idx    = paddr[ADDR_W-1:2];

    bcg_step #(
        .DOORBELL_REPEAT (DOORBELL_REPEAT)
    ) u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .req        (req),
        .state_next (state_calc)
    );

    always_comb
    begin
        state_next     = state_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (req_accept)
        begin
            state_next               = state_calc;
            rsp_next.buzzer_on       = state_calc.sound_phase;
            rsp_next.current_pattern = state_calc.pattern;
            rsp_valid_next           = 1'b1;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_idx)
                REG_DOORBELL_ON:   cfg_next.doorbell_on_ticks   = pwdata[TICK_W-1:0];
                REG_DOORBELL_OFF:  cfg_next.doorbell_off_ticks  = pwdata[TICK_W-1:0];
                REG_INTRUSION_ON:  cfg_next.intrusion_on_ticks  = pwdata[TICK_W-1:0];
                REG_INTRUSION_OFF: cfg_next.intrusion_off_ticks = pwdata[TICK_W-1:0];
                REG_GAS_ON:        cfg_next.gas_on_ticks        = pwdata[TICK_W-1:0];
                REG_GAS_OFF:       cfg_next.gas_off_ticks       = pwdata[TICK_W-1:0];
                REG_LOCKOUT_ON:    cfg_next.lockout_on_ticks    = pwdata[TICK_W-1:0];
                REG_LOCKOUT_OFF:   cfg_next.lockout_off_ticks   = pwdata[TICK_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DOORBELL_ON:   read_ticks = cfg_reg.doorbell_on_ticks;
            REG_DOORBELL_OFF:  read_ticks = cfg_reg.doorbell_off_ticks;
            REG_INTRUSION_ON:  read_ticks = cfg_reg.intrusion_on_ticks;
            REG_INTRUSION_OFF: read_ticks = cfg_reg.intrusion_off_ticks;
            REG_GAS_ON:        read_ticks = cfg_reg.gas_on_ticks;
            REG_GAS_OFF:       read_ticks = cfg_reg.gas_off_ticks;
            REG_LOCKOUT_ON:    read_ticks = cfg_reg.lockout_on_ticks;
            REG_LOCKOUT_OFF:   read_ticks = cfg_reg.lockout_off_ticks;
            default:           read_ticks = '0;
        endcase
    end

    assign prdata = DATA_W'(read_ticks);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            cfg_reg       <= '{default: CFG_RESET_TICKS};
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `BCG_ASSERT(a_off_is_silent, (state_reg.pattern != PAT_OFF) || !state_reg.sound_phase, "buzzer sounding with no pattern")
    `BCG_ASSERT(a_repeats_doorbell_only, (state_reg.repeats_left == '0) || (state_reg.pattern == PAT_DOORBELL), "repeat count outside doorbell pattern")
    `BCG_ASSERT(a_rsp_tracks_state, !rsp_valid_reg || ((rsp_reg.current_pattern == state_reg.pattern) && (rsp_reg.buzzer_on == state_reg.sound_phase)), "response differs from cadence state")
    `BCG_ASSERT_NEXT(a_request_answered, req_accept, rsp_valid_reg, "accepted request left no response")

endmodule

/* tb/sv/buzzer_cadence_generator_test.sv */
`timescale 1ns / 100ps

module buzzer_cadence_generator_test;
    import bcg_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam logic [PAT_W-1:0] PAT_SEL_BAD = PAT_LOCKOUT + 3'd1;
    localparam logic [PAT_W-1:0] PAT_SEL_MAX = 3'd7;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES = 6;

    typedef struct {
        req_t r;
        bit   typed;
        rsp_t want;
    } row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    req_t              req = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    rsp_t              rsp;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // cadence state as predicted from the accepted requests
    logic [TICK_W-1:0] len_ticks [8];
    logic [PAT_W-1:0]  cad_pattern;
    logic              cad_sound;
    logic [TICK_W-1:0] cad_count;
    logic [TICK_W-1:0] cad_repeats;

    rsp_t drive_queue [$];
    int   mismatches = 0;
    int   sent = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   quiet_cycles = 0;

    int phase_items [PHASES] = '{300, 250, 350, 400, 300, 300};
    int phase_run   [PHASES] = '{40, 12, 30, 600, 60, 20};
    int phase_idle  [PHASES] = '{0, 68, 0, 18, 18, 68};
    int phase_stall [PHASES] = '{0, 0, 68, 18, 18, 0};

    row_t directed_rows [18] = '{
        '{'{CMD_TICK, PAT_OFF},           1'b1, '{1'b0, PAT_OFF}},
        '{'{CMD_STOP, PAT_LOCKOUT},       1'b1, '{1'b0, PAT_OFF}},
        '{'{CMD_UNUSED, PAT_SEL_MAX},     1'b1, '{1'b0, PAT_OFF}},
        '{'{CMD_START, PAT_SEL_BAD},      1'b1, '{1'b0, PAT_OFF}},
        '{'{CMD_START, PAT_SEL_MAX},      1'b1, '{1'b0, PAT_OFF}},
        '{'{CMD_START, PAT_DOORBELL},     1'b1, '{1'b1, PAT_DOORBELL}},
        '{'{CMD_START, PAT_DOORBELL},     1'b1, '{1'b1, PAT_DOORBELL}},
        '{'{CMD_TICK, PAT_SEL_MAX},       1'b1, '{1'b1, PAT_DOORBELL}},
        '{'{CMD_START, PAT_INTRUSION},    1'b0, '{1'b0, PAT_OFF}},
        '{'{CMD_START, PAT_SEL_BAD},      1'b0, '{1'b0, PAT_OFF}},
        '{'{CMD_UNUSED, PAT_OFF},         1'b0, '{1'b0, PAT_OFF}},
        '{'{CMD_START, PAT_OFF},          1'b1, '{1'b0, PAT_OFF}},
        '{'{CMD_START, PAT_GAS},          1'b0, '{1'b0, PAT_OFF}},
        '{'{CMD_TICK, PAT_GAS},           1'b0, '{1'b0, PAT_OFF}},
        '{'{CMD_STOP, PAT_OFF},           1'b1, '{1'b0, PAT_OFF}},
        '{'{CMD_START, PAT_LOCKOUT},      1'b1, '{1'b1, PAT_LOCKOUT}},
        '{'{CMD_TICK, PAT_OFF},           1'b0, '{1'b0, PAT_OFF}},
        '{'{CMD_START, PAT_GAS},          1'b0, '{1'b0, PAT_OFF}}
    };

    buzzer_cadence_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic stop_cadence();
        cad_pattern = PAT_OFF;
        cad_sound = 1'b0;
        cad_count = '0;
        cad_repeats = '0;
    endtask

    task automatic advance_cadence(input req_t r, output rsp_t drive);
        int base;
        logic [TICK_W-1:0] limit;
        case (r.cmd)
            CMD_TICK:
                if (cad_pattern != PAT_OFF && cad_pattern <= PAT_LOCKOUT)
                begin
                    base = (int'(cad_pattern) - 1) * 2;
                    limit = cad_sound ? len_ticks[base] : len_ticks[base + 1];
                    cad_count = cad_count + 8'd1;
                    if (cad_count >= limit)
                    begin
                        cad_count = '0;
                        cad_sound = ~cad_sound;
                        // doorbell counts its sounding phases down to a self stop
                        if (!cad_sound && cad_pattern == PAT_DOORBELL && cad_repeats != 0)
                        begin
                            cad_repeats = cad_repeats - 8'd1;
                            if (cad_repeats == 0)
                                stop_cadence();
                        end
                    end
                end
            CMD_START:
                if (r.pattern_sel == PAT_OFF)
                    stop_cadence();
                else if (r.pattern_sel <= PAT_LOCKOUT && r.pattern_sel != cad_pattern)
                begin
                    cad_pattern = r.pattern_sel;
                    cad_sound = 1'b1;
                    cad_count = '0;
                    cad_repeats = (r.pattern_sel == PAT_DOORBELL) ?
                                  TICK_W'(DOORBELL_REPEAT_DEF) : '0;
                end
            CMD_STOP:
                stop_cadence();
            default:
                ;
        endcase
        drive.buzzer_on = cad_sound;
        drive.current_pattern = cad_pattern;
    endtask

    task automatic send_req(input req_t r, input bit typed, input rsp_t want);
        rsp_t drive;
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        advance_cadence(r, drive);
        drive_queue.push_back(typed ? want : drive);
        sent++;
    endtask

    function automatic req_t noise_req();
        req_t r;
        case ($urandom_range(2))
            0:
            begin
                r.cmd = CMD_UNUSED;
                r.pattern_sel = PAT_W'($urandom_range(PAT_SEL_MAX));
            end
            1:
            begin
                r.cmd = CMD_START;
                r.pattern_sel = PAT_W'($urandom_range(PAT_SEL_MAX, PAT_SEL_BAD));
            end
            default:
            begin
                // the running pattern again (ignored), a switch, or off
                r.cmd = CMD_START;
                r.pattern_sel = PAT_W'($urandom_range(PAT_LOCKOUT));
            end
        endcase
        return r;
    endfunction

    // start a pattern, tick it for a while, sometimes stop it
    task automatic run_burst(input int max_run);
        req_t r;
        int n;
        r.cmd = CMD_START;
        r.pattern_sel = PAT_W'($urandom_range(PAT_LOCKOUT, PAT_DOORBELL));
        if ($urandom_range(9) == 0)
            r = noise_req();
        send_req(r, 1'b0, '0);
        n = $urandom_range(max_run, 1);
        repeat (n)
        begin
            r.cmd = CMD_TICK;
            r.pattern_sel = PAT_W'($urandom_range(PAT_SEL_MAX));
            if ($urandom_range(max_run / 2 + 10) == 0)
                r = noise_req();
            send_req(r, 1'b0, '0);
        end
        if ($urandom_range(9) < 3)
        begin
            r.cmd = $urandom_range(1) ? CMD_STOP : CMD_START;
            r.pattern_sel = (r.cmd == CMD_STOP) ? 3'($urandom_range(PAT_SEL_MAX)) : PAT_OFF;
            send_req(r, 1'b0, '0);
        end
    endtask

    task automatic write_len(input int idx, input logic [TICK_W-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx * 4);
        pwdata <= {(DATA_W - TICK_W)'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        len_ticks[idx] = val;
    endtask

    // response checker and random back pressure
    initial
    begin
        rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                if (drive_queue.size() == 0)
                    report_mismatch("response with no request outstanding");
                else
                begin
                    want = drive_queue.pop_front();
                    if (rsp.buzzer_on !== want.buzzer_on)
                        report_mismatch($sformatf("buzzer_on got %b want %b",
                                                  rsp.buzzer_on, want.buzzer_on));
                    if (rsp.current_pattern !== want.current_pattern)
                        report_mismatch($sformatf("current_pattern got %0d want %0d",
                                                  rsp.current_pattern, want.current_pattern));
                end
            end
            rsp_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
            (psel && penable && pwrite && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [TICK_W-1:0] val;
        for (int i = REG_DOORBELL_ON; i <= REG_LOCKOUT_OFF; i++)
            len_ticks[i] = CFG_RESET_TICKS;
        stop_cadence();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph != 0)
            begin
                // drain before touching the tick lengths
                req_valid <= 1'b0;
                while (drive_queue.size() != 0)
                    @(posedge clk);
                repeat (4) @(posedge clk);
                for (int i = REG_DOORBELL_ON; i <= REG_LOCKOUT_OFF; i++)
                begin
                    case (ph)
                        1: val = '0;
                        2: val = TICK_W'($urandom_range(5));
                        3: val = '1;
                        4: val = $urandom_range(1) ? TICK_W'($urandom_range(255)) :
                                                     TICK_W'($urandom_range(12));
                        default: val = 8'd1;
                    endcase
                    write_len(i, val);
                end
            end
            idle_pct = phase_idle[ph];
            stall_pct = phase_stall[ph];
            sent = 0;
            if (ph == 0)
                foreach (directed_rows[k])
                    send_req(directed_rows[k].r, directed_rows[k].typed, directed_rows[k].want);
            // keep the last burst inside the phase budget
            while (sent < phase_items[ph])
                run_burst((phase_items[ph] - sent < phase_run[ph]) ?
                          phase_items[ph] - sent : phase_run[ph]);
        end

        req_valid <= 1'b0;
        while (drive_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
